// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the complex arithmetic unit.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CAU_ASSERT_IMP(label, clk, rst_n, pre, post) \
	`CAU_ASSERT(label, clk, rst_n, (pre) |-> (post))
`else
`define CAU_ASSERT(label, clk, rst_n, prop)
`define CAU_ASSERT_IMP(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
	// action codes on the input
	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_SCALE = 3'd2;
	localparam logic [2:0] ACT_IMUL  = 3'd3;
	localparam logic [2:0] ACT_CMUL  = 3'd4;
	localparam logic [2:0] ACT_MAG   = 3'd5;

	// operation class decided by the front end
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_ADD,
		CLS_SUB,
		CLS_MUL,
		CLS_MAG
	} op_class_t;

	localparam int CLS_BITS    = 3;
	localparam int QUEUE_DEPTH = 4;
endpackage
`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// Front end: accepts requests, classifies the action and sets up operands.
// Depends on cau_pkg; feeds cau_queue.
`timescale 1ns / 1ps
`default_nettype none
module cau_front #(
	parameter int DW = 32
) (
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           action,
	input  wire logic signed [DW-1:0] a_real,
	input  wire logic signed [DW-1:0] a_imag,
	input  wire logic signed [DW-1:0] b_real,
	input  wire logic signed [DW-1:0] b_imag,
	input  wire logic                 q_full,
	output logic                      q_push,
	output logic [cau_pkg::CLS_BITS+4*DW-1:0] q_data
);
	import cau_pkg::*;

	op_class_t     cls;
	logic [DW-1:0] y_re;
	logic [DW-1:0] y_im;

	// class and operand substitution per action
	always_comb begin
		cls  = CLS_NONE;
		y_re = b_real;
		y_im = b_imag;
		unique case (action)
			ACT_ADD: cls = CLS_ADD;
			ACT_SUB: cls = CLS_SUB;
			ACT_SCALE: begin
				cls  = CLS_MUL;
				y_im = '0;
			end
			ACT_IMUL: begin
				cls  = CLS_MUL;
				y_re = '0;
			end
			ACT_CMUL: cls = CLS_MUL;
			ACT_MAG: begin
				// squares come out of the same multipliers
				cls  = CLS_MAG;
				y_re = a_real;
				y_im = a_imag;
			end
			default: cls = CLS_NONE;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_data   = {cls, a_real, a_imag, y_re, y_im};
endmodule
`default_nettype wire

// ===== rtl/core/cau_queue.sv =====
// Short FIFO between front end and back end.
// Depends on cau_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module cau_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);
	import cau_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [0:QUEUE_DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full     = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= AW'((wr_ptr_q + 1'b1) % QUEUE_DEPTH);
			if (pop)  rd_ptr_q <= AW'((rd_ptr_q + 1'b1) % QUEUE_DEPTH);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/cau_back.sv =====
// Back end: product stage, combine and clip stage, bit-per-stage square root.
// Depends on cau_pkg and assert_macros.svh; fed by cau_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cau_back #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [cau_pkg::CLS_BITS+4*DW-1:0] in_data,
	output logic                      in_pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [DW-1:0]      res_real,
	output logic signed [DW-1:0]      res_imag,
	output logic                      is_magnitude,
	output logic                      saturated
);
	import cau_pkg::*;

	localparam int PW  = 2 * DW;
	localparam int RMW = DW + 3;
	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	op_class_t             in_cls;
	logic [CLS_BITS-1:0]   in_cls_bits;
	logic signed [DW-1:0]  x_re, x_im, y_re, y_im;
	logic                  adv;

	assign {in_cls_bits, x_re, x_im, y_re, y_im} = in_data;
	assign in_cls = op_class_t'(in_cls_bits);
	assign adv    = !(out_valid && out_stall);
	assign in_pop = adv && in_valid;

	// stage 1: four products and the add/sub sums
	logic                 valid_s1;
	op_class_t            cls_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [DW:0]          sum_re_s1, sum_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (adv) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= in_cls;
			p_rr_s1 <= x_re * y_re;
			p_ii_s1 <= x_im * y_im;
			p_ri_s1 <= x_re * y_im;
			p_ir_s1 <= x_im * y_re;
			if (in_cls == CLS_SUB) begin
				sum_re_s1 <= {x_re[DW-1], x_re} - {y_re[DW-1], y_re};
				sum_im_s1 <= {x_im[DW-1], x_im} - {y_im[DW-1], y_im};
			end else begin
				sum_re_s1 <= {x_re[DW-1], x_re} + {y_re[DW-1], y_re};
				sum_im_s1 <= {x_im[DW-1], x_im} + {y_im[DW-1], y_im};
			end
		end
	end

	// stage 2 logic: combine products, shift, clip
	logic signed [PW:0] mul_re, mul_im, sh_re, sh_im;
	logic               fit_re, fit_im, fa_re, fa_im;
	logic [DW-1:0]      c_re, c_im;
	logic               c_sat;
	logic [PW-1:0]      c_rad;

	always_comb begin
		mul_re = $signed({p_rr_s1[PW-1], p_rr_s1}) - $signed({p_ii_s1[PW-1], p_ii_s1});
		mul_im = $signed({p_ri_s1[PW-1], p_ri_s1}) + $signed({p_ir_s1[PW-1], p_ir_s1});
		sh_re  = mul_re >>> FB;
		sh_im  = mul_im >>> FB;
		fit_re = (&sh_re[PW:DW-1]) || !(|sh_re[PW:DW-1]);
		fit_im = (&sh_im[PW:DW-1]) || !(|sh_im[PW:DW-1]);
		fa_re  = (sum_re_s1[DW] == sum_re_s1[DW-1]);
		fa_im  = (sum_im_s1[DW] == sum_im_s1[DW-1]);
		c_rad  = p_rr_s1 + p_ii_s1;
		c_re   = '0;
		c_im   = '0;
		c_sat  = 1'b0;
		unique case (cls_s1)
			CLS_ADD, CLS_SUB: begin
				c_re  = fa_re ? sum_re_s1[DW-1:0] : (sum_re_s1[DW] ? MINV : MAXV);
				c_im  = fa_im ? sum_im_s1[DW-1:0] : (sum_im_s1[DW] ? MINV : MAXV);
				c_sat = !fa_re || !fa_im;
			end
			CLS_MUL: begin
				c_re  = fit_re ? sh_re[DW-1:0] : (sh_re[PW] ? MINV : MAXV);
				c_im  = fit_im ? sh_im[DW-1:0] : (sh_im[PW] ? MINV : MAXV);
				c_sat = !fit_re || !fit_im;
			end
			CLS_MAG:  c_sat = 1'b0;
			CLS_NONE: c_sat = 1'b0;
			default:  c_sat = 1'b0;
		endcase
	end

	// root stages: index 0 is stage 2, each further stage settles one root bit
	logic            vld_s  [0:DW];
	op_class_t       cls_s  [0:DW];
	logic [DW-1:0]   re_s   [0:DW];
	logic [DW-1:0]   im_s   [0:DW];
	logic            sat_s  [0:DW];
	logic [PW-1:0]   rad_s  [0:DW];
	logic [RMW-1:0]  rem_s  [0:DW];
	logic [DW-1:0]   root_s [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (adv) vld_s[0] <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s[0]  <= cls_s1;
			re_s[0]   <= c_re;
			im_s[0]   <= c_im;
			sat_s[0]  <= c_sat;
			rad_s[0]  <= c_rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < DW; j++) begin : g_root
		logic [RMW-1:0] remsh, trial;
		logic           take;

		always_comb begin
			remsh = {rem_s[j][RMW-3:0], rad_s[j][PW-1:PW-2]};
			trial = {1'b0, root_s[j], 2'b01};
			take  = (remsh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j+1] <= 1'b0;
			else if (adv) vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cls_s[j+1]  <= cls_s[j];
				re_s[j+1]   <= re_s[j];
				im_s[j+1]   <= im_s[j];
				sat_s[j+1]  <= sat_s[j];
				rad_s[j+1]  <= {rad_s[j][PW-3:0], 2'b00};
				rem_s[j+1]  <= take ? (remsh - trial) : remsh;
				root_s[j+1] <= {root_s[j][DW-2:0], take};
			end
		end
	end

	// result selection from the last stage
	logic root_big;

	assign root_big  = root_s[DW][DW-1];
	assign out_valid = vld_s[DW];

	always_comb begin
		if (cls_s[DW] == CLS_MAG) begin
			res_real     = root_big ? MAXV : root_s[DW];
			res_imag     = '0;
			is_magnitude = 1'b1;
			saturated    = root_big;
		end else begin
			res_real     = re_s[DW];
			res_imag     = im_s[DW];
			is_magnitude = 1'b0;
			saturated    = sat_s[DW];
		end
	end

	`CAU_ASSERT_IMP(a_mag_imag_zero, clk, arst_n, out_valid && is_magnitude, res_imag == '0)
	`CAU_ASSERT_IMP(a_mag_nonneg, clk, arst_n, out_valid && is_magnitude, !res_real[DW-1])
	`CAU_ASSERT_IMP(a_pop_valid, clk, arst_n, in_pop, in_valid)
	`CAU_ASSERT(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(res_real))
endmodule
`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction.
// Path of a request: queue, product stage, combine stage, then one square-root stage per
// root bit, so the root pipeline length sets the latency.
// Throughput: one request per cycle while out_stall does not hold the pipeline.
// Reset: arst_n clears queue and pipeline valid state asynchronously.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   action,
	input  wire logic signed [DATA_WIDTH-1:0] a_real,
	input  wire logic signed [DATA_WIDTH-1:0] a_imag,
	input  wire logic signed [DATA_WIDTH-1:0] b_real,
	input  wire logic signed [DATA_WIDTH-1:0] b_imag,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      res_real,
	output logic signed [DATA_WIDTH-1:0]      res_imag,
	output logic                              is_magnitude,
	output logic                              saturated
);
	import cau_pkg::*;

	localparam int QW = CLS_BITS + 4 * DATA_WIDTH;

	logic          q_full, q_push, q_pop, q_empty;
	logic [QW-1:0] q_wdata, q_rdata;

	// classify requests
	cau_front #(.DW(DATA_WIDTH)) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.a_real   (a_real),
		.a_imag   (a_imag),
		.b_real   (b_real),
		.b_imag   (b_imag),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// decoupling queue
	cau_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// arithmetic pipeline
	cau_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_empty),
		.in_data      (q_rdata),
		.in_pop       (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.res_real     (res_real),
		.res_imag     (res_imag),
		.is_magnitude (is_magnitude),
		.saturated    (saturated)
	);
endmodule
`default_nettype wire

// ===== tb/complex_arithmetic_unit_tb.sv =====
// Self-checking testbench of complex_arithmetic_unit: directed cases, random requests
// and back-pressure, each result checked against a built-in fixed-point predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam logic signed [DW-1:0] QMAX = 32'sh7fffffff;
	localparam logic signed [DW-1:0] QMIN = 32'sh80000000;
	localparam logic signed [DW-1:0] ONE  = 32'sh00010000;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 mag;
		logic                 sat;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = '0;
	logic signed [DW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] res_real, res_imag;
	logic is_magnitude, saturated;

	cplx_result_t result_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .a_real(a_real), .a_imag(a_imag),
		.b_real(b_real), .b_imag(b_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_real(res_real), .res_imag(res_imag),
		.is_magnitude(is_magnitude), .saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// clip a wide value to the signed data range
	function automatic logic signed [DW-1:0] clip_q(input logic signed [127:0] v,
			inout logic sat);
		if (v > 128'(QMAX)) begin
			sat = 1'b1;
			return QMAX;
		end
		if (v < 128'sd0 - 128'sd2147483648) begin
			sat = 1'b1;
			return QMIN;
		end
		return v[DW-1:0];
	endfunction

	// expected result of one request
	function automatic cplx_result_t complex_result(input logic [2:0] act,
			input logic signed [DW-1:0] ar, ai, br, bi);
		logic signed [127:0] xr, xi, yr, yi, w;
		logic [127:0] sq, root, c;
		cplx_result_t r;
		logic sat;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		sat = 1'b0;
		r = '0;
		case (act)
			ACT_ADD: begin
				r.re = clip_q(xr + yr, sat);
				r.im = clip_q(xi + yi, sat);
			end
			ACT_SUB: begin
				r.re = clip_q(xr - yr, sat);
				r.im = clip_q(xi - yi, sat);
			end
			ACT_SCALE, ACT_IMUL, ACT_CMUL: begin
				if (act == ACT_SCALE) yi = 0;
				if (act == ACT_IMUL) yr = 0;
				w = (xr * yr - xi * yi) >>> FB;
				r.re = clip_q(w, sat);
				w = (xr * yi + xi * yr) >>> FB;
				r.im = clip_q(w, sat);
			end
			ACT_MAG: begin
				sq = xr * xr + xi * xi;
				root = '0;
				for (int k = 49; k >= 0; k--) begin
					c = root | (128'd1 << k);
					if (c * c <= sq) root = c;
				end
				r.re = clip_q($signed(root), sat);
				r.im = '0;
				r.mag = 1'b1;
			end
			default: ;
		endcase
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
		errors++;
	endtask

	// drive one request and wait for it to be accepted
	task automatic send_request(input logic [2:0] act,
			input logic signed [DW-1:0] ar, ai, br, bi);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		a_real = ar;
		a_imag = ai;
		b_real = br;
		b_imag = bi;
		do @(posedge clk); while (in_stall);
		result_q.push_back(complex_result(act, ar, ai, br, bi));
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		go_idle();
		while (result_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? QMAX : QMIN;
			1: return $signed($urandom_range(0, 20 * ONE)) - 10 * ONE;
			2: return $signed($urandom_range(0, 400)) - 200;
			default: return $urandom;
		endcase
	endfunction

	// receiver: random stall, or a long hold when asked
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		cplx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				report_mismatch("unexpected result", res_real, 0);
			end else begin
				want = result_q.pop_front();
				if (res_real !== want.re) report_mismatch("res_real", res_real, want.re);
				if (res_imag !== want.im) report_mismatch("res_imag", res_imag, want.im);
				if (is_magnitude !== want.mag)
					report_mismatch("is_magnitude", is_magnitude, want.mag);
				if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
			end
		end
	end

	task automatic test_directed();
		send_request(ACT_ADD, ONE, -ONE, 3 * ONE, 2 * ONE);
		send_request(ACT_ADD, QMAX, QMAX, 1, QMIN);
		send_request(ACT_ADD, QMIN, QMIN, -1, QMIN);
		send_request(ACT_SUB, QMIN, QMAX, 1, -1);
		send_request(ACT_SUB, 5 * ONE, 0, 2 * ONE, ONE);
		send_request(ACT_SCALE, 3 * ONE, -2 * ONE, ONE / 2, QMAX);
		send_request(ACT_SCALE, QMAX, QMIN, QMAX, 0);
		send_request(ACT_SCALE, -1, 1, 1, 0);
		send_request(ACT_IMUL, 2 * ONE, 3 * ONE, QMIN, 4 * ONE);
		send_request(ACT_IMUL, QMIN, QMIN, 0, QMIN);
		send_request(ACT_CMUL, ONE, ONE, ONE, -ONE);
		send_request(ACT_CMUL, QMIN, QMIN, QMIN, QMIN);
		send_request(ACT_CMUL, QMAX, QMIN, QMAX, QMAX);
		send_request(ACT_CMUL, -3, 5, 7, -11);
		send_request(ACT_MAG, 3 * ONE, 4 * ONE, QMAX, QMIN);
		send_request(ACT_MAG, QMIN, QMIN, 0, 0);
		send_request(ACT_MAG, QMAX, 0, 0, 0);
		send_request(ACT_MAG, 0, 0, 0, 0);
		send_request(ACT_MAG, 1, 1, 0, 0);
		send_request(ACT_SPARE6, QMAX, QMIN, QMAX, QMIN);
		send_request(ACT_SPARE7, -1, -1, -1, -1);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		logic [2:0] act;
		for (int n = 0; n < count; n++) begin
			act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			send_request(act, rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end
		wait_drained();
	endtask

	// long receiver hold while requests keep coming: pipeline fills and stalls input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_cycles = 150;
		for (int n = 0; n < 60; n++)
			send_request(3'($urandom_range(0, 5)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 45;
		test_directed();
		test_random(150);

		send_idle_pct = 45;
		recv_idle_pct = 11;
		test_random(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(100);

		test_backpressure();

		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
